/* rtl/mlfq_pkg.sv */
package mlfq_pkg;

   // Task slot states.
   typedef enum logic [1:0] {
      ES_UNUSED = 2'd0,
      ES_READY  = 2'd1,
      ES_RUN    = 2'd2,
      ES_SLEEP  = 2'd3
   } entry_state_type;

   // Command codes on the request channel.
   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_CREATE = 3'd1,
      CMD_WAKE   = 3'd2,
      CMD_BLOCK  = 3'd3,
      CMD_EXIT   = 3'd4
   } cmd_type;

   // Broadcast operation applied by every cell in the same cycle.
   typedef enum logic [2:0] {
      CK_NOP    = 3'd0,
      CK_TICK   = 3'd1,
      CK_CREATE = 3'd2,
      CK_WAKE   = 3'd3,
      CK_AGE    = 3'd4,
      CK_RUN    = 3'd5
   } cell_kind_type;

   typedef struct packed {
      cell_kind_type   kind;
      logic            leave;
      entry_state_type leave_state;
      logic            demote;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      SS_IDLE = 2'd0,
      SS_AGE  = 2'd1,
      SS_SCAN = 2'd2,
      SS_DISP = 2'd3
   } sched_state_type;

   localparam int CMD_W      = 3;
   localparam int SLOT_W     = 6;
   localparam int CHAN_W     = 16;
   localparam int OUT_LVL_W  = 3;
   localparam int SLICE_MAX  = 255;
   localparam int CFG_SLICES = 0;
   localparam int CFG_AGES   = 1;
   localparam logic [39:0] SLICE_RESET = 40'h10_0804_0201;
   localparam logic [31:0] AGE_RESET   = 32'h140F_0A05;

endpackage

/* rtl/mlfq_process_scheduler.sv */
// When a task still runs after the command, the response is registered at
// the transfer; otherwise the command is applied at its transfer, followed
// by an ageing state, one scan step per cell and a dispatch state.
// One item is in flight at a time; the next transfer is taken once the
// result has been taken.
// Reset clears every slot to unused, time, slice count and the run flag,
// and loads the default slice and aging tables.
module mlfq_process_scheduler #(
   parameter int ENTRIES   = 64,
   parameter int LEVELS    = 5,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // cmd[2:0], slot[8:3], channel[24:9], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // running_valid[0], running_slot[6:1],
                                    // running_level[9:7], status[10], zeros
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [39:0] csr_wdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   // Request fields.
   logic [mlfq_pkg::CMD_W-1:0]  req_cmd;
   logic [mlfq_pkg::SLOT_W-1:0] req_slot;
   logic [mlfq_pkg::CHAN_W-1:0] req_chan;
   assign req_cmd  = req_tdata[2:0];
   assign req_slot = req_tdata[8:3];
   assign req_chan = req_tdata[24:9];

   // Control state of the sequencer and the scheduler registers.
   mlfq_pkg::sched_state_type state_ff, state_in;
   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic                 run_ff, run_in;
   logic [IDX_W-1:0]     run_idx_ff, run_idx_in;
   logic [LVL_W-1:0]     run_lvl_ff, run_lvl_in;
   logic [7:0]           used_ff, used_in, used_inc;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [39:0]          slice_ff;
   logic [31:0]          age_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic                 status;
   logic                 accept;

   logic [7:0] slice_tbl [LEVELS];
   logic [7:0] age_tbl   [LEVELS];

   // Broadcast to the cells.
   mlfq_pkg::cell_ctl_type       ctl;
   logic [IDX_W-1:0]             target;
   logic [TIME_BITS-1:0]         now;

   // Candidate chain through the row of cells.
   logic                 ch_valid [ENTRIES+1];
   logic [IDX_W-1:0]     ch_idx   [ENTRIES+1];
   logic [LVL_W-1:0]     ch_lvl   [ENTRIES+1];
   logic [TIME_BITS-1:0] ch_key   [ENTRIES+1];
   logic [ENTRIES-1:0]   unused_vec;

   // Level tables: levels past the fifth share the last byte.
   always_comb begin
      int b;
      int a;
      for (int l = 0; l < LEVELS; l++) begin
         b = (l > 4) ? 4 : l;
         a = (l > 4) ? 3 : ((l == 0) ? 0 : l - 1);
         slice_tbl[l] = slice_ff[8*b +: 8];
         age_tbl[l]   = age_ff[8*a +: 8];
      end
   end

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == mlfq_pkg::SS_IDLE) && !rsp_valid_ff;
   assign used_inc   = (used_ff == 8'(mlfq_pkg::SLICE_MAX)) ? used_ff : used_ff + 8'd1;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlfq_pkg::SS_IDLE: if (accept && !run_in) state_in = mlfq_pkg::SS_AGE;
         mlfq_pkg::SS_AGE:  state_in = mlfq_pkg::SS_SCAN;
         mlfq_pkg::SS_SCAN: if (scan_ff == IDX_W'(ENTRIES - 1)) state_in = mlfq_pkg::SS_DISP;
         mlfq_pkg::SS_DISP: state_in = mlfq_pkg::SS_IDLE;
         default:           state_in = mlfq_pkg::SS_IDLE;
      endcase
   end

   // Output logic: cell commands and scheduler register updates.
   always_comb begin
      ctl         = '{kind: mlfq_pkg::CK_NOP, leave: 1'b0,
                      leave_state: mlfq_pkg::ES_READY, demote: 1'b0};
      target      = run_idx_ff;
      now         = tick_ff;
      tick_in     = tick_ff;
      run_in      = run_ff;
      run_idx_in  = run_idx_ff;
      run_lvl_in  = run_lvl_ff;
      used_in     = used_ff;
      scan_in     = '0;
      status      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         mlfq_pkg::SS_IDLE: begin
            if (accept) begin
               unique case (req_cmd) inside
                  mlfq_pkg::CMD_TICK: begin
                     tick_in  = tick_ff + 1'b1;
                     now      = tick_in;
                     ctl.kind = mlfq_pkg::CK_TICK;
                     if (run_ff) begin
                        used_in = used_inc;
                        if (used_inc >= slice_tbl[run_lvl_ff]) begin
                           ctl.leave       = 1'b1;
                           ctl.leave_state = mlfq_pkg::ES_READY;
                           ctl.demote      = (run_lvl_ff < LVL_W'(LEVELS - 1));
                           run_in          = 1'b0;
                        end
                     end
                  end
                  mlfq_pkg::CMD_CREATE: begin
                     target = IDX_W'(req_slot);
                     if (32'(req_slot) >= 32'(ENTRIES) || !unused_vec[target]) begin
                        status = 1'b1;
                     end else begin
                        ctl.kind = mlfq_pkg::CK_CREATE;
                     end
                  end
                  mlfq_pkg::CMD_WAKE: ctl.kind = mlfq_pkg::CK_WAKE;
                  mlfq_pkg::CMD_BLOCK, mlfq_pkg::CMD_EXIT: begin
                     if (!run_ff) begin
                        status = 1'b1;
                     end else begin
                        ctl.leave       = 1'b1;
                        ctl.leave_state = (req_cmd == mlfq_pkg::CMD_BLOCK) ?
                                          mlfq_pkg::ES_SLEEP : mlfq_pkg::ES_UNUSED;
                        ctl.demote      = (used_ff >= slice_tbl[run_lvl_ff]) &&
                                          (run_lvl_ff < LVL_W'(LEVELS - 1));
                        run_in          = 1'b0;
                     end
                  end
                  default: status = 1'b1;
               endcase
               rsp_status_in = status;
               if (run_in) rsp_valid_in = 1'b1;
            end
         end
         mlfq_pkg::SS_AGE: ctl.kind = mlfq_pkg::CK_AGE;
         mlfq_pkg::SS_SCAN: scan_in = scan_ff + 1'b1;
         mlfq_pkg::SS_DISP: begin
            rsp_valid_in = 1'b1;
            if (ch_valid[ENTRIES]) begin
               ctl.kind   = mlfq_pkg::CK_RUN;
               target     = ch_idx[ENTRIES];
               run_in     = 1'b1;
               run_idx_in = ch_idx[ENTRIES];
               run_lvl_in = ch_lvl[ENTRIES];
               used_in    = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlfq_pkg::SS_IDLE;
         tick_ff      <= '0;
         run_ff       <= 1'b0;
         run_idx_ff   <= '0;
         run_lvl_ff   <= '0;
         used_ff      <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         slice_ff     <= mlfq_pkg::SLICE_RESET;
         age_ff       <= mlfq_pkg::AGE_RESET;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         run_ff       <= run_in;
         run_idx_ff   <= run_idx_in;
         run_lvl_ff   <= run_lvl_in;
         used_ff      <= used_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_addr == 1'(mlfq_pkg::CFG_SLICES)) slice_ff <= csr_wdata;
         if (csr_we && csr_addr == 1'(mlfq_pkg::CFG_AGES))   age_ff   <= csr_wdata[31:0];
      end
      rsp_status_ff <= rsp_status_in;
   end

   // The chain starts empty at the first cell.
   assign ch_valid[0] = 1'b0;
   assign ch_idx[0]   = '0;
   assign ch_lvl[0]   = '0;
   assign ch_key[0]   = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      mlfq_cell #(
         .INDEX(i), .LEVELS(LEVELS), .TIME_BITS(TIME_BITS), .IDX_W(IDX_W), .LVL_W(LVL_W)
      ) u_cell (
         .clock(clock), .reset(reset), .ctl(ctl), .target(target), .now(now),
         .chan(req_chan), .age_tbl(age_tbl),
         .cin_valid(ch_valid[i]), .cin_idx(ch_idx[i]), .cin_lvl(ch_lvl[i]),
         .cin_key(ch_key[i]),
         .cout_valid(ch_valid[i+1]), .cout_idx(ch_idx[i+1]), .cout_lvl(ch_lvl[i+1]),
         .cout_key(ch_key[i+1]),
         .unused(unused_vec[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_status_ff,
                        run_ff ? mlfq_pkg::OUT_LVL_W'(run_lvl_ff) : 3'd0,
                        run_ff ? mlfq_pkg::SLOT_W'(run_idx_ff) : 6'd0,
                        run_ff};

endmodule

/* rtl/mlfq_cell.sv */
module mlfq_cell #(
   parameter int INDEX     = 0,
   parameter int LEVELS    = 5,
   parameter int TIME_BITS = 32,
   parameter int IDX_W     = 6,
   parameter int LVL_W     = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mlfq_pkg::cell_ctl_type     ctl,
   input  logic [IDX_W-1:0]           target,
   input  logic [TIME_BITS-1:0]       now,
   input  logic [mlfq_pkg::CHAN_W-1:0] chan,
   input  logic [7:0]                 age_tbl [LEVELS],
   input  logic                       cin_valid,
   input  logic [IDX_W-1:0]           cin_idx,
   input  logic [LVL_W-1:0]           cin_lvl,
   input  logic [TIME_BITS-1:0]       cin_key,
   output logic                       cout_valid,
   output logic [IDX_W-1:0]           cout_idx,
   output logic [LVL_W-1:0]           cout_lvl,
   output logic [TIME_BITS-1:0]       cout_key,
   output logic                       unused
);

   mlfq_pkg::entry_state_type st_ff, st_in;
   logic [LVL_W-1:0]           lvl_ff, lvl_in;
   logic [TIME_BITS-1:0]       ct_ff, ct_in, lr_ff, lr_in, key, age_gap;
   logic [mlfq_pkg::CHAN_W-1:0] tag_ff, tag_in;
   logic                       hit, better;
   logic                       cv_ff;
   logic [IDX_W-1:0]           ci_ff;
   logic [LVL_W-1:0]           cl_ff;
   logic [TIME_BITS-1:0]       ck_ff;

   assign hit     = (target == IDX_W'(INDEX));
   assign age_gap = now - lr_ff;
   assign unused  = (st_ff == mlfq_pkg::ES_UNUSED);

   always_comb begin
      st_in  = st_ff;
      lvl_in = lvl_ff;
      ct_in  = ct_ff;
      lr_in  = lr_ff;
      tag_in = tag_ff;
      case (ctl.kind)
         mlfq_pkg::CK_TICK: begin
            if (st_ff == mlfq_pkg::ES_SLEEP) lr_in = lr_ff + 1'b1;
         end
         mlfq_pkg::CK_CREATE: begin
            if (hit) begin
               st_in  = mlfq_pkg::ES_READY;
               ct_in  = now;
               lr_in  = now;
               lvl_in = '0;
            end
         end
         mlfq_pkg::CK_WAKE: begin
            if (st_ff == mlfq_pkg::ES_SLEEP && tag_ff == chan) st_in = mlfq_pkg::ES_READY;
         end
         mlfq_pkg::CK_AGE: begin
            if (st_ff == mlfq_pkg::ES_READY && lvl_ff != '0 &&
                age_gap > TIME_BITS'(age_tbl[lvl_ff])) begin
               lvl_in = lvl_ff - 1'b1;
               lr_in  = now;
            end
         end
         mlfq_pkg::CK_RUN: begin
            if (hit) begin
               st_in = mlfq_pkg::ES_RUN;
               lr_in = now;
            end
         end
         default: ;
      endcase
      if (ctl.leave && hit) begin
         st_in = ctl.leave_state;
         if (ctl.leave_state != mlfq_pkg::ES_UNUSED) begin
            if (ctl.demote) lvl_in = lvl_ff + 1'b1;
            lr_in = now;
         end
         if (ctl.leave_state == mlfq_pkg::ES_SLEEP) tag_in = chan;
      end
   end

   // Bottom level orders by last run, the others by creation time.
   assign key    = (lvl_ff == LVL_W'(LEVELS - 1)) ? lr_ff : ct_ff;
   assign better = (st_ff == mlfq_pkg::ES_READY) &&
                   (!cin_valid || lvl_ff < cin_lvl || (lvl_ff == cin_lvl && key < cin_key));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= mlfq_pkg::ES_UNUSED;
      end else begin
         st_ff <= st_in;
      end
      lvl_ff <= lvl_in;
      ct_ff  <= ct_in;
      lr_ff  <= lr_in;
      tag_ff <= tag_in;
      cv_ff  <= better | cin_valid;
      ci_ff  <= better ? IDX_W'(INDEX) : cin_idx;
      cl_ff  <= better ? lvl_ff : cin_lvl;
      ck_ff  <= better ? key : cin_key;
   end

   assign cout_valid = cv_ff;
   assign cout_idx   = ci_ff;
   assign cout_lvl   = cl_ff;
   assign cout_key   = ck_ff;

endmodule
